/* rtl/core/nlp_pkg.sv */
`default_nettype none

package nlp_pkg;

   localparam int VALUE_BITS  = 32;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CHAR_COLON      = 8'h3A;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CHAR_DOLLAR     = 8'h24;
   localparam logic [7:0] CHAR_PERCENT    = 8'h25;
   localparam logic [7:0] CHAR_ZERO       = 8'h30;
   localparam logic [7:0] CHAR_ONE        = 8'h31;
   localparam logic [7:0] CHAR_NINE       = 8'h39;
   localparam logic [7:0] CHAR_LOWER_X    = 8'h78;
   localparam logic [7:0] CHAR_LOWER_B    = 8'h62;
   localparam logic [7:0] CHAR_LOWER_A    = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F    = 8'h66;
   localparam logic [7:0] CHAR_UPPER_A    = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F    = 8'h46;

   localparam logic [1:0] POS_FIRST  = 2'd0;
   localparam logic [1:0] POS_SECOND = 2'd1;
   localparam logic [1:0] POS_LATER  = 2'd2;

   typedef enum logic [1:0] {
      RADIX_DEC = 2'd0,
      RADIX_HEX = 2'd1,
      RADIX_BIN = 2'd2
   } radix_type;

   typedef enum logic [1:0] {
      OP_SKIP  = 2'd0,
      OP_DIGIT = 2'd1,
      OP_BAD   = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef struct packed {
      logic [7:0] character;
      logic       last_char;
   } req_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      logic                  valid_res;
   } rsp_type;

   typedef struct packed {
      op_type     op;
      radix_type  radix;
      logic [3:0] digit;
      logic       last;
   } op_entry_type;

endpackage

`default_nettype wire

/* rtl/core/nlp_front.sv */
`default_nettype none

module nlp_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire nlp_pkg::req_type     req_item,
   input  wire logic                 queue_full,
   output logic                      push,
   output nlp_pkg::op_entry_type     push_entry
);

   logic [1:0]         pos_ff, pos_in;
   logic               pending_ff, pending_in;
   nlp_pkg::radix_type radix_ff, radix_in;
   logic [7:0]         c;
   logic               last;

   function automatic nlp_pkg::op_entry_type classify(input logic [7:0] ch,
                                                      input nlp_pkg::radix_type r);
      nlp_pkg::op_entry_type e;
      e.op    = nlp_pkg::OP_BAD;
      e.radix = r;
      e.digit = 4'd0;
      e.last  = 1'b0;
      if (ch == nlp_pkg::CHAR_COLON || ch == nlp_pkg::CHAR_UNDERSCORE) begin
         e.op = nlp_pkg::OP_SKIP;
      end else begin
         case (r)
            nlp_pkg::RADIX_HEX: begin
               if (ch inside {[nlp_pkg::CHAR_ZERO:nlp_pkg::CHAR_NINE]}) begin
                  e.op    = nlp_pkg::OP_DIGIT;
                  e.digit = ch[3:0];
               end else if (ch inside {[nlp_pkg::CHAR_LOWER_A:nlp_pkg::CHAR_LOWER_F],
                                       [nlp_pkg::CHAR_UPPER_A:nlp_pkg::CHAR_UPPER_F]}) begin
                  e.op    = nlp_pkg::OP_DIGIT;
                  e.digit = ch[3:0] + 4'd9;
               end
            end
            nlp_pkg::RADIX_BIN: begin
               if (ch == nlp_pkg::CHAR_ZERO || ch == nlp_pkg::CHAR_ONE) begin
                  e.op    = nlp_pkg::OP_DIGIT;
                  e.digit = ch[3:0];
               end
            end
            default: begin
               if (ch inside {[nlp_pkg::CHAR_ZERO:nlp_pkg::CHAR_NINE]}) begin
                  e.op    = nlp_pkg::OP_DIGIT;
                  e.digit = ch[3:0];
               end
            end
         endcase
      end
      return e;
   endfunction

   assign c         = req_item.character;
   assign last      = req_item.last_char;
   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      push_entry = classify(c, radix_ff);
      radix_in   = radix_ff;
      pending_in = 1'b0;
      if (pos_ff == nlp_pkg::POS_FIRST) begin
         if (!last && c == nlp_pkg::CHAR_DOLLAR) begin
            radix_in      = nlp_pkg::RADIX_HEX;
            push_entry.op = nlp_pkg::OP_SKIP;
         end else if (!last && c == nlp_pkg::CHAR_PERCENT) begin
            radix_in      = nlp_pkg::RADIX_BIN;
            push_entry.op = nlp_pkg::OP_SKIP;
         end else begin
            radix_in   = nlp_pkg::RADIX_DEC;
            pending_in = !last && c == nlp_pkg::CHAR_ZERO;
            push_entry = classify(c, nlp_pkg::RADIX_DEC);
         end
      end else if (pos_ff == nlp_pkg::POS_SECOND && pending_ff) begin
         if (!last && c == nlp_pkg::CHAR_LOWER_X) begin
            radix_in      = nlp_pkg::RADIX_HEX;
            push_entry.op = nlp_pkg::OP_CLEAR;
         end else if (!last && c == nlp_pkg::CHAR_LOWER_B) begin
            radix_in      = nlp_pkg::RADIX_BIN;
            push_entry.op = nlp_pkg::OP_CLEAR;
         end
      end
      push_entry.last = last;

      pos_in = (pos_ff == nlp_pkg::POS_LATER) ? nlp_pkg::POS_LATER : pos_ff + 2'd1;
      if (last) begin
         pos_in     = nlp_pkg::POS_FIRST;
         radix_in   = nlp_pkg::RADIX_DEC;
         pending_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= nlp_pkg::POS_FIRST;
         pending_ff <= 1'b0;
         radix_ff   <= nlp_pkg::RADIX_DEC;
      end else if (push) begin
         pos_ff     <= pos_in;
         pending_ff <= pending_in;
         radix_ff   <= radix_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/nlp_queue.sv */
`default_nettype none

module nlp_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire nlp_pkg::op_entry_type push_entry,
   output logic                       full,
   output logic                       not_empty,
   input  wire logic                  pop,
   output nlp_pkg::op_entry_type      pop_entry
);

   nlp_pkg::op_entry_type             mem_ff [nlp_pkg::QUEUE_DEPTH];
   logic [nlp_pkg::QPTR_BITS-1:0]     wr_ff, rd_ff;
   logic [nlp_pkg::QCNT_BITS-1:0]     count_ff;

   assign full      = count_ff == nlp_pkg::QCNT_BITS'(nlp_pkg::QUEUE_DEPTH);
   assign not_empty = count_ff != '0;
   assign pop_entry = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= (wr_ff == nlp_pkg::QPTR_BITS'(nlp_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= (rd_ff == nlp_pkg::QPTR_BITS'(nlp_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

/* rtl/core/nlp_back.sv */
`default_nettype none

module nlp_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  entry_ready,
   input  wire nlp_pkg::op_entry_type entry,
   output logic                       pop,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output nlp_pkg::rsp_type           rsp_item
);

   logic [nlp_pkg::VALUE_BITS-1:0] acc_ff, acc_in, digit_ext;
   logic                           bad_ff, bad_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   nlp_pkg::rsp_type               rsp_item_ff, rsp_item_in;

   assign pop       = entry_ready && (!rsp_valid_ff || !rsp_stall);
   assign digit_ext = nlp_pkg::VALUE_BITS'(entry.digit);

   always_comb begin
      acc_in = acc_ff;
      bad_in = bad_ff;
      case (entry.op)
         nlp_pkg::OP_DIGIT: begin
            case (entry.radix)
               nlp_pkg::RADIX_HEX: acc_in = {acc_ff[nlp_pkg::VALUE_BITS-5:0], 4'b0000} | digit_ext;
               nlp_pkg::RADIX_BIN: acc_in = {acc_ff[nlp_pkg::VALUE_BITS-2:0], entry.digit[0]};
               default:            acc_in = (acc_ff << 3) + (acc_ff << 1) + digit_ext;
            endcase
         end
         nlp_pkg::OP_CLEAR: acc_in = '0;
         nlp_pkg::OP_BAD:   bad_in = 1'b1;
         default:           acc_in = acc_ff;
      endcase
   end

   always_comb begin
      rsp_item_in.value     = bad_in ? '0 : acc_in;
      rsp_item_in.valid_res = !bad_in;
      if (pop && entry.last) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         bad_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            acc_ff <= entry.last ? '0 : acc_in;
            bad_ff <= entry.last ? 1'b0 : bad_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && entry.last) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

`default_nettype wire

/* rtl/core/numeric_literal_parser.sv */
// Numeric literal parser: turns an ASCII number string into a 32-bit value.
// Input channel (req_): one character per item, req_item.last_char marks the
// end of the string. A leading "0x" or "$" means hex, "0b" or "%" binary,
// otherwise decimal; ':' and '_' are ignored, anything else marks the
// string bad. The value wraps modulo 2^32.
// Result channel (rsp_): one item per string, sent for its last character:
// value (zero when bad) and valid_res.
// Throughput: one character per cycle while rsp_stall holds no result; the
// shift-and-add in the back end is combinational.
// A last character is registered in the queue and then in the result
// register before its result shows on rsp_.
// A two-entry queue sits between the classifying front end and the
// accumulating back end; while rsp_stall holds a result the back end takes
// nothing, and req_stall rises once the queue holds two items. A held
// result does not change.
// Reset (synchronous, active high) clears the queue, the prefix tracking,
// the accumulator and any pending result; req_stall is low after reset.
`default_nettype none

module numeric_literal_parser (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire nlp_pkg::req_type req_item,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output nlp_pkg::rsp_type      rsp_item
);

   logic                  queue_full;
   logic                  push;
   nlp_pkg::op_entry_type push_entry;
   logic                  queue_not_empty;
   logic                  pop;
   nlp_pkg::op_entry_type pop_entry;

   nlp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   nlp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .not_empty  (queue_not_empty),
      .pop        (pop),
      .pop_entry  (pop_entry)
   );

   nlp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .entry_ready (queue_not_empty),
      .entry       (pop_entry),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_item    (rsp_item)
   );

endmodule

`default_nettype wire

/* rtl/core/nlp_checker.sv */
`default_nettype none

module nlp_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire nlp_pkg::req_type req_item,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire nlp_pkg::rsp_type rsp_item
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("result item changed while stalled");

   a_bad_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.valid_res |-> rsp_item.value == '0)
      else $error("bad string with nonzero value");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> $past(rsp_valid && rsp_stall))
      else $error("input stalled without a blocked result");

   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !req_stall)
      else $error("result or stall present after reset");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_item))
      else $error("input item changed while stalled");

endmodule

bind numeric_literal_parser nlp_checker u_nlp_checker (.*);

`default_nettype wire

/* test/tb_numeric_literal_parser.sv */
module tb_numeric_literal_parser;
   import nlp_pkg::*;

   typedef enum int {
      FORM_DEC,
      FORM_0X,
      FORM_DOLLAR,
      FORM_0B,
      FORM_PERCENT
   } literal_form;

   typedef struct {
      req_type item;
      logic    typed;
      rsp_type want;
   } script_row;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_item = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_item;

   logic [31:0] lit_acc;
   radix_type   lit_radix;
   logic [1:0]  lit_pos;
   logic        lit_bad;
   logic        lit_zero_lead;

   rsp_type   pending_literals [$];
   rsp_type   oldest;
   script_row script [$];
   int        mismatches = 0;
   int        sent_chars = 0;
   int        burst_left = 0;
   int        stall_mode = 0;
   int        stall_left = 0;
   logic [7:0] stall_tick = '0;

   always #5 clock = ~clock;

   numeric_literal_parser dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   task automatic clear_parser();
      lit_acc       = '0;
      lit_radix     = RADIX_DEC;
      lit_pos       = POS_FIRST;
      lit_bad       = 1'b0;
      lit_zero_lead = 1'b0;
   endtask

   task automatic fold_char(input logic [7:0] c);
      logic [31:0] base;
      logic [3:0]  d;
      logic        ok;
      if (c == CHAR_COLON || c == CHAR_UNDERSCORE) return;
      ok = 1'b1;
      d = '0;
      case (lit_radix)
         RADIX_HEX: begin
            base = 32'd16;
            if (c >= CHAR_ZERO && c <= CHAR_NINE) d = 4'(c - CHAR_ZERO);
            else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) d = 4'(c - CHAR_LOWER_A + 8'd10);
            else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) d = 4'(c - CHAR_UPPER_A + 8'd10);
            else ok = 1'b0;
         end
         RADIX_BIN: begin
            base = 32'd2;
            if (c == CHAR_ZERO || c == CHAR_ONE) d = 4'(c - CHAR_ZERO);
            else ok = 1'b0;
         end
         default: begin
            base = 32'd10;
            if (c >= CHAR_ZERO && c <= CHAR_NINE) d = 4'(c - CHAR_ZERO);
            else ok = 1'b0;
         end
      endcase
      if (ok) lit_acc = lit_acc * base + 32'(d);
      else lit_bad = 1'b1;
   endtask

   task automatic predict_literal(input req_type it, output logic done, output rsp_type res);
      logic [7:0] c;
      logic       last;
      c = it.character;
      last = it.last_char;
      done = 1'b0;
      res = '0;
      if (lit_pos == POS_FIRST) begin
         if (!last && c == CHAR_DOLLAR) lit_radix = RADIX_HEX;
         else if (!last && c == CHAR_PERCENT) lit_radix = RADIX_BIN;
         else begin
            lit_radix = RADIX_DEC;
            if (!last && c == CHAR_ZERO) lit_zero_lead = 1'b1;
            fold_char(c);
         end
      end else if (lit_pos == POS_SECOND && lit_zero_lead) begin
         lit_zero_lead = 1'b0;
         if (!last && c == CHAR_LOWER_X) begin
            lit_radix = RADIX_HEX;
            lit_acc = '0;
         end else if (!last && c == CHAR_LOWER_B) begin
            lit_radix = RADIX_BIN;
            lit_acc = '0;
         end else begin
            fold_char(c);
         end
      end else begin
         lit_zero_lead = 1'b0;
         fold_char(c);
      end
      if (lit_pos != POS_LATER) lit_pos = lit_pos + 2'd1;
      if (last) begin
         done = 1'b1;
         res.value = lit_bad ? '0 : lit_acc;
         res.valid_res = !lit_bad;
         clear_parser();
      end
   endtask

   task automatic push_char(input req_type it, input logic typed, input rsp_type want,
                            input logic drain);
      logic    done;
      rsp_type res;
      req_item <= it;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_literal(it, done, res);
      if (done) pending_literals.push_back(typed ? want : res);
      sent_chars++;
      burst_left--;
      if (drain || burst_left <= 0) begin
         req_valid <= 1'b0;
         if (drain) while (pending_literals.size() != 0) @(posedge clock);
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 30);
      end
   endtask

   task automatic add_step(input logic [7:0] c, input logic last, input logic typed,
                           input logic [31:0] v, input logic ok);
      script_row r;
      r.item.character = c;
      r.item.last_char = last;
      r.typed = typed;
      r.want.value = v;
      r.want.valid_res = ok;
      script.push_back(r);
   endtask

   function automatic logic [7:0] random_digit(input literal_form form);
      logic [7:0] d;
      if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? CHAR_COLON : CHAR_UNDERSCORE;
      case (form)
         FORM_0X, FORM_DOLLAR: begin
            d = 8'($urandom_range(0, 15));
            if (d < 8'd10) return CHAR_ZERO + d;
            return ($urandom_range(0, 1) ? CHAR_LOWER_A : CHAR_UPPER_A) + d - 8'd10;
         end
         FORM_0B, FORM_PERCENT: return CHAR_ZERO + 8'($urandom_range(0, 1));
         default: return CHAR_ZERO + 8'($urandom_range(0, 9));
      endcase
   endfunction

   task automatic send_random_literal(input logic drain);
      logic [7:0]  text [$];
      int          kind;
      int          n;
      literal_form form;
      req_type     it;
      kind = $urandom_range(0, 99);
      if (kind < 80) begin
         form = literal_form'($urandom_range(0, 4));
         case (form)
            FORM_0X: begin
               text.push_back(CHAR_ZERO);
               text.push_back(CHAR_LOWER_X);
            end
            FORM_DOLLAR: text.push_back(CHAR_DOLLAR);
            FORM_0B: begin
               text.push_back(CHAR_ZERO);
               text.push_back(CHAR_LOWER_B);
            end
            FORM_PERCENT: text.push_back(CHAR_PERCENT);
            default: ;
         endcase
         n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
         repeat (n) text.push_back(random_digit(form));
         if (kind >= 65) text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
      end else begin
         repeat ($urandom_range(1, 4)) text.push_back(8'($urandom_range(0, 255)));
      end
      foreach (text[i]) begin
         it.character = text[i];
         it.last_char = (i == text.size() - 1);
         push_char(it, 1'b0, '0, drain && it.last_char);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_literals.size() == 0) begin
            $display("%0t: unexpected item: expected none, actual value %h valid_res %b",
                     $time, rsp_item.value, rsp_item.valid_res);
            mismatches++;
         end else begin
            oldest = pending_literals.pop_front();
            if (rsp_item.value !== oldest.value) begin
               $display("%0t: value mismatch: expected %h, actual %h",
                        $time, oldest.value, rsp_item.value);
               mismatches++;
            end
            if (rsp_item.valid_res !== oldest.valid_res) begin
               $display("%0t: valid_res mismatch: expected %b, actual %b",
                        $time, oldest.valid_res, rsp_item.valid_res);
               mismatches++;
            end
         end
      end
      stall_tick <= stall_tick + 8'd1;
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(20, 200);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= 1'($urandom_range(0, 1));
         2: rsp_stall <= ($urandom_range(0, 9) != 0);
         default: rsp_stall <= stall_tick[2] & stall_tick[0];
      endcase
   end

   initial begin
      logic mid_drained;
      clear_parser();
      burst_left = $urandom_range(1, 30);
      mid_drained = 1'b0;

      add_step(CHAR_ZERO, 1'b1, 1'b1, 32'd0, 1'b1);
      add_step(CHAR_DOLLAR, 1'b1, 1'b1, 32'd0, 1'b0);
      add_step(CHAR_PERCENT, 1'b1, 1'b1, 32'd0, 1'b0);
      add_step(CHAR_ZERO, 1'b0, 1'b0, 32'd0, 1'b0);
      add_step(CHAR_LOWER_X, 1'b1, 1'b1, 32'd0, 1'b0);
      add_step(CHAR_ZERO, 1'b0, 1'b0, 32'd0, 1'b0);
      add_step(CHAR_LOWER_B, 1'b1, 1'b1, 32'd0, 1'b0);
      add_step(CHAR_ZERO, 1'b0, 1'b0, 32'd0, 1'b0);
      add_step("X", 1'b0, 1'b0, 32'd0, 1'b0);
      add_step(CHAR_ONE, 1'b1, 1'b1, 32'd0, 1'b0);
      add_step(CHAR_DOLLAR, 1'b0, 1'b0, 32'd0, 1'b0);
      add_step(CHAR_LOWER_F, 1'b0, 1'b0, 32'd0, 1'b0);
      add_step(CHAR_UPPER_F, 1'b1, 1'b0, 32'd0, 1'b0);
      add_step(CHAR_PERCENT, 1'b0, 1'b0, 32'd0, 1'b0);
      add_step(CHAR_ONE, 1'b0, 1'b0, 32'd0, 1'b0);
      add_step(CHAR_UNDERSCORE, 1'b0, 1'b0, 32'd0, 1'b0);
      add_step(CHAR_ZERO, 1'b1, 1'b0, 32'd0, 1'b0);
      add_step(CHAR_ZERO, 1'b0, 1'b0, 32'd0, 1'b0);
      add_step(CHAR_LOWER_X, 1'b0, 1'b0, 32'd0, 1'b0);
      add_step(CHAR_COLON, 1'b1, 1'b1, 32'd0, 1'b1);
      add_step(8'hFF, 1'b1, 1'b1, 32'd0, 1'b0);
      add_step(8'h00, 1'b1, 1'b1, 32'd0, 1'b0);
      add_step(CHAR_NINE, 1'b1, 1'b0, 32'd0, 1'b0);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i])
         push_char(script[i].item, script[i].typed, script[i].want, i == script.size() - 1);

      while (sent_chars < 1350) begin
         send_random_literal(!mid_drained && sent_chars >= 700);
         if (sent_chars >= 700) mid_drained = 1'b1;
      end
      send_random_literal(1'b1);
      repeat (8) @(posedge clock);

      if (mismatches == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #5000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
